// ===== src/bounded_line_splitter_macros.svh =====
// assertion helpers used by the rtl
`ifndef BOUNDED_LINE_SPLITTER_MACROS_SVH
`define BOUNDED_LINE_SPLITTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bls_pkg.sv =====
package bls_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 64;

  localparam int MAX_LINE_W = 6;
  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;

  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RESET = 6'd63;
  localparam logic [BYTE_W-1:0]     NL_BYTE        = 8'h0A;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_DATA = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EOS  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ERR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_BYTE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EOS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_REPLAY
  } state_t;

endpackage

// ===== src/bounded_line_splitter.sv =====
// timing: a status word appears in the output register in the cycle after its input word
// is taken; the bytes of a replayed line pass from the store read register to the output register
// throughput: one input word per cycle while no line is replayed and the output does not stall; a line of n
// bytes replays at one byte per cycle while the output does not stall, and holds the input off until its last byte
// reset: synchronous active-low rst_n clears control and sets max_line to 63;
// the line memory is not cleared and needs no clearing pass
module bounded_line_splitter #(
  parameter int BUFFER_DEPTH = bls_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bls_pkg::MAX_LINE_W-1:0] cfg_data,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bls_pkg::ACTION_W-1:0]   in_action,
  input  logic [bls_pkg::BYTE_W-1:0]     in_data_byte,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bls_pkg::STATUS_W-1:0]   out_status,
  output logic [bls_pkg::BYTE_W-1:0]     out_byte,
  output logic [bls_pkg::LEN_W-1:0]      out_line_length,
  output logic                          out_last
);

  `include "bounded_line_splitter_macros.svh"

  // address and count widths follow the buffer depth
  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int CW  = $clog2(BUFFER_DEPTH + 1);
  // width wide enough for both the chunk size and the fill count
  localparam int CHW = (CW > bls_pkg::LEN_W) ? CW : bls_pkg::LEN_W;

  // configuration register
  logic [bls_pkg::MAX_LINE_W-1:0] max_line_r;

  // control state
  bls_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          skip_r, skip_nxt;

  // replay read side
  logic [CW-1:0] len_r, len_nxt;       // line length being replayed
  logic [CW-1:0] rd_idx_r, rd_idx_nxt; // next entry to read
  logic          rd_valid_r, rd_valid_nxt;
  logic          rd_last_r, rd_last_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bls_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bls_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic [CW-1:0]                 out_len_r, out_len_nxt;
  logic                          out_last_r, out_last_nxt;

  // memory interface
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic                       mem_re;
  logic [bls_pkg::BYTE_W-1:0] mem_rdata;

  logic [CHW-1:0] ml_plus1;
  logic [CHW-1:0] chunk;
  logic [CW-1:0]  fill_eff;
  logic [CW-1:0]  fill_inc;
  logic           out_free;
  logic           in_accept;
  logic           load_now;

  // chunk size is max_line + 1, capped at the buffer depth
  assign ml_plus1 = CHW'(max_line_r) + CHW'(1);
  assign chunk    = (ml_plus1 > CHW'(BUFFER_DEPTH)) ? CHW'(BUFFER_DEPTH) : ml_plus1;

  // a fill left over from a larger chunk restarts at zero
  assign fill_eff = (CHW'(fill_r) >= chunk) ? '0 : fill_r;
  assign fill_inc = fill_eff + CW'(1);

  // the output slot can take a word at this edge
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != bls_pkg::S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // move read data into the output slot during replay
  assign load_now = (state_r == bls_pkg::S_REPLAY) && rd_valid_r && out_free;

  // keep the read register full when there is room behind it
  assign mem_re = (state_r == bls_pkg::S_REPLAY) && (rd_idx_r != len_r) &&
                  (!rd_valid_r || load_now);

  // every data word lands in the store at its fill position
  assign mem_we    = in_accept && (in_action == bls_pkg::ACT_DATA);
  assign mem_waddr = fill_eff[AW-1:0];

  bls_line_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data_byte),
    .re    (mem_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= bls_pkg::MAX_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_line_r <= cfg_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, line bookkeeping and output slot
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    skip_nxt       = skip_r;
    len_nxt        = len_r;
    rd_idx_nxt     = rd_idx_r;
    rd_valid_nxt   = rd_valid_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    // the current word leaves the slot
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bls_pkg::S_IDLE: begin
        if (in_accept) begin
          case (in_action)
            bls_pkg::ACT_DATA: begin
              if (in_data_byte == bls_pkg::NL_BYTE) begin
                fill_nxt = '0;
                if (skip_r) begin
                  // newline closes a skipped line
                  skip_nxt       = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = bls_pkg::ST_LONG;
                  out_byte_nxt   = '0;
                  out_len_nxt    = '0;
                  out_last_nxt   = 1'b1;
                end else begin
                  // line fits, replay it from the store
                  len_nxt      = fill_inc;
                  rd_idx_nxt   = '0;
                  rd_valid_nxt = 1'b0;
                  state_nxt    = bls_pkg::S_REPLAY;
                end
              end else if (CHW'(fill_inc) >= chunk) begin
                // chunk filled without a newline
                fill_nxt       = '0;
                skip_nxt       = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_LONG;
                out_byte_nxt   = '0;
                out_len_nxt    = '0;
                out_last_nxt   = 1'b1;
              end else begin
                fill_nxt = fill_inc;
              end
            end
            bls_pkg::ACT_EOS: begin
              fill_nxt       = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = bls_pkg::ST_EOS;
              out_byte_nxt   = '0;
              out_len_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            bls_pkg::ACT_ERR: begin
              fill_nxt       = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = bls_pkg::ST_ERR;
              out_byte_nxt   = '0;
              out_len_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            default: begin
              // unused action, word dropped with no result
            end
          endcase
        end
      end
      bls_pkg::S_REPLAY: begin
        if (mem_re) begin
          rd_idx_nxt   = rd_idx_r + CW'(1);
          rd_last_nxt  = ((rd_idx_r + CW'(1)) == len_r);
          rd_valid_nxt = 1'b1;
        end else if (load_now) begin
          rd_valid_nxt = 1'b0;
        end
        if (load_now) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bls_pkg::ST_BYTE;
          out_byte_nxt   = mem_rdata;
          out_len_nxt    = len_r;
          out_last_nxt   = rd_last_r;
          if (rd_last_r) begin
            state_nxt = bls_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bls_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      skip_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      len_r       <= '0;
    end else begin
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      len_r       <= len_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_last_r    <= rd_last_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_byte        = out_byte_r;
  assign out_line_length = bls_pkg::LEN_W'(out_len_r);
  assign out_last        = out_last_r;

  // replay never reads past the line it is sending
  `BLS_ASSERT_NOW(a_rd_in_line, state_r == bls_pkg::S_REPLAY, rd_idx_r <= len_r, "replay index past line end")
  // read data is only held while a line is replayed
  `BLS_ASSERT_NOW(a_rd_only_replay, rd_valid_r, state_r == bls_pkg::S_REPLAY, "read data outside replay")
  // a status word is always the only result of its input
  `BLS_ASSERT_NOW(a_status_last, out_valid_r && (out_status_r != bls_pkg::ST_BYTE), out_last_r, "status word without last")
  // the final byte of a line hands control back to the input side
  `BLS_ASSERT_NEXT(a_last_ends_replay, load_now && rd_last_r, state_r == bls_pkg::S_IDLE, "replay did not end after last byte")

endmodule

// ===== src/bls_line_mem.sv =====
module bls_line_mem #(
  parameter int DEPTH = bls_pkg::DEFAULT_BUFFER_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bls_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [bls_pkg::BYTE_W-1:0] rdata
);

  logic [bls_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bls_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
